@@ src/wai_alu_pkg.sv @@
// ----------------------------------------------------------------------------
// wai_alu_pkg
// opcodes and shared types of the width aware integer alu
// ----------------------------------------------------------------------------
package wai_alu_pkg;

  typedef enum logic [4:0] {
    OP_EQ   = 5'd0,  OP_NE   = 5'd1,  OP_LT   = 5'd2,  OP_GT   = 5'd3,
    OP_LE   = 5'd4,  OP_GE   = 5'd5,  OP_NOTL = 5'd6,  OP_ANDL = 5'd7,
    OP_ORL  = 5'd8,  OP_INV  = 5'd9,  OP_ANDB = 5'd10, OP_ORB  = 5'd11,
    OP_XORB = 5'd12, OP_ANDR = 5'd13, OP_ORR  = 5'd14, OP_XORR = 5'd15,
    OP_SHL  = 5'd16, OP_SHR  = 5'd17, OP_ADD  = 5'd18, OP_SUB  = 5'd19,
    OP_NEG  = 5'd20, OP_MUL  = 5'd21, OP_DIV  = 5'd22, OP_MOD  = 5'd23,
    OP_PAD  = 5'd24
  } opcode_t;

  localparam int unsigned OpWidth = 5;
  localparam int unsigned WWidth  = 6;

endpackage

@@ src/wai_alu_if.sv @@
// ----------------------------------------------------------------------------
// wai_alu_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface wai_alu_req_if #(parameter int DATA_WIDTH = 32);
  logic                                valid;
  logic                                ready;
  logic [wai_alu_pkg::OpWidth-1:0]     opcode;
  logic                                signed_mode;
  logic [DATA_WIDTH-1:0]               operand_a;
  logic [DATA_WIDTH-1:0]               operand_b;
  logic [wai_alu_pkg::WWidth-1:0]      a_width;
  logic [wai_alu_pkg::WWidth-1:0]      b_width;
  logic [wai_alu_pkg::WWidth-1:0]      result_width;
  modport source (output valid, opcode, signed_mode, operand_a, operand_b,
                  a_width, b_width, result_width, input ready);
  modport sink   (input valid, opcode, signed_mode, operand_a, operand_b,
                  a_width, b_width, result_width, output ready);
endinterface

interface wai_alu_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;
  logic                  bad_opcode;
  modport source (output valid, result, bad_opcode, input ready);
  modport sink   (input valid, result, bad_opcode, output ready);
endinterface

@@ src/wai_alu_front.sv @@
// ----------------------------------------------------------------------------
// wai_alu_front
// clamps widths, resizes operands and classifies the request
// ----------------------------------------------------------------------------
module wai_alu_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [wai_alu_pkg::OpWidth-1:0] opcode,
  input  logic                            signed_mode,
  input  logic [DATA_WIDTH-1:0]           operand_a,
  input  logic [DATA_WIDTH-1:0]           operand_b,
  input  logic [wai_alu_pkg::WWidth-1:0]  a_width,
  input  logic [wai_alu_pkg::WWidth-1:0]  b_width,
  input  logic [wai_alu_pkg::WWidth-1:0]  result_width,
  output logic [wai_alu_pkg::OpWidth-1:0] op_o,
  output logic                            sgn_o,
  output logic [DATA_WIDTH-1:0]           a_o,
  output logic [DATA_WIDTH-1:0]           b_o,
  output logic [DATA_WIDTH-1:0]           rmask_o,
  output logic [wai_alu_pkg::WWidth:0]    rw_o,
  output logic                            early_o,
  output logic [DATA_WIDTH-1:0]           early_val_o,
  output logic                            bad_o
);
  localparam int WW = wai_alu_pkg::WWidth + 1;
  localparam logic [WW-1:0] DW = WW'(DATA_WIDTH);

  logic [WW-1:0] aw, bw, rw, cw;
  logic [DATA_WIDTH-1:0] am, bm, a0, b0, ca, cb, cmask, rm, asx, bsx;
  logic lt_ab, lt_ba, eq_ab;

  function automatic logic [WW-1:0] clampw(input logic [wai_alu_pkg::WWidth-1:0] w);
    logic [WW-1:0] x;
    x = {1'b0, w};
    if (x == '0) return WW'(1);
    if (x > DW) return DW;
    return x;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] wmask(input logic [WW-1:0] w);
    logic [DATA_WIDTH-1:0] m;
    for (int i = 0; i < DATA_WIDTH; i++) m[i] = (WW'(i) < w);
    return m;
  endfunction

  // sign extend from width w to the full datapath
  function automatic logic [DATA_WIDTH-1:0] sx(input logic [DATA_WIDTH-1:0] v,
                                               input logic [WW-1:0] w,
                                               input logic [DATA_WIDTH-1:0] m);
    logic s;
    s = v[$clog2(DATA_WIDTH)'(w - WW'(1))];
    return s ? (v | ~m) : v;
  endfunction

  always_comb begin
    aw = clampw(a_width);
    bw = clampw(b_width);
    rw = clampw(result_width);
    cw = (aw > bw) ? aw : bw;
    am = wmask(aw);
    bm = wmask(bw);
    rm = wmask(rw);
    cmask = wmask(cw);
    a0 = operand_a & am;
    b0 = operand_b & bm;
    asx = signed_mode ? sx(a0, aw, am) : a0;
    bsx = signed_mode ? sx(b0, bw, bm) : b0;
    ca = asx & cmask;
    cb = bsx & cmask;
    eq_ab = (ca == cb);
    if (signed_mode) begin
      lt_ab = $signed(asx) < $signed(bsx);
      lt_ba = $signed(bsx) < $signed(asx);
    end else begin
      lt_ab = a0 < b0;
      lt_ba = b0 < a0;
    end
    early_o = 1'b1;
    bad_o = 1'b0;
    early_val_o = '0;
    unique case (opcode)
      wai_alu_pkg::OP_EQ:   early_val_o[0] = eq_ab;
      wai_alu_pkg::OP_NE:   early_val_o[0] = !eq_ab;
      wai_alu_pkg::OP_LT:   early_val_o[0] = lt_ab;
      wai_alu_pkg::OP_GT:   early_val_o[0] = lt_ba;
      wai_alu_pkg::OP_LE:   early_val_o[0] = !lt_ba;
      wai_alu_pkg::OP_GE:   early_val_o[0] = !lt_ab;
      wai_alu_pkg::OP_NOTL: early_val_o[0] = (a0 == '0);
      wai_alu_pkg::OP_ANDL: early_val_o[0] = (a0 != '0) && (b0 != '0);
      wai_alu_pkg::OP_ORL:  early_val_o[0] = (a0 != '0) || (b0 != '0);
      wai_alu_pkg::OP_ANDR: early_val_o[0] = (a0 == am);
      wai_alu_pkg::OP_ORR:  early_val_o[0] = (a0 != '0);
      wai_alu_pkg::OP_XORR: early_val_o[0] = ^a0;
      wai_alu_pkg::OP_INV, wai_alu_pkg::OP_ANDB, wai_alu_pkg::OP_ORB,
      wai_alu_pkg::OP_XORB, wai_alu_pkg::OP_SHL, wai_alu_pkg::OP_SHR,
      wai_alu_pkg::OP_ADD, wai_alu_pkg::OP_SUB, wai_alu_pkg::OP_NEG,
      wai_alu_pkg::OP_MUL, wai_alu_pkg::OP_DIV, wai_alu_pkg::OP_MOD,
      wai_alu_pkg::OP_PAD:  early_o = 1'b0;
      default:              bad_o = 1'b1;
    endcase
    early_val_o = early_val_o & rm;
    op_o = opcode;
    sgn_o = signed_mode;
    a_o = asx & rm;
    b_o = bsx & rm;
    rmask_o = rm;
    rw_o = rw;
  end
endmodule

@@ src/wai_alu_queue.sv @@
// ----------------------------------------------------------------------------
// wai_alu_queue
// two entry fifo between front and back
// ----------------------------------------------------------------------------
module wai_alu_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  logic [WIDTH-1:0] mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ src/wai_alu_divider.sv @@
// ----------------------------------------------------------------------------
// wai_alu_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module wai_alu_divider #(
  parameter int DATA_WIDTH = 32,
  parameter int TAG_WIDTH  = 8
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  input  logic [TAG_WIDTH-1:0]  tag_i,
  output logic [DATA_WIDTH-1:0] quo,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [TAG_WIDTH-1:0]  tag_o
);
  logic [DATA_WIDTH-1:0] q   [1:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] r   [1:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] d   [1:DATA_WIDTH];
  logic [TAG_WIDTH-1:0]  t   [1:DATA_WIDTH];

  for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_stage
    logic [DATA_WIDTH-1:0] q_in, r_in, d_in;
    logic [TAG_WIDTH-1:0]  t_in;
    logic [DATA_WIDTH:0] part, diff;
    // first stage takes the operands, the others the previous stage
    if (s == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign t_in = tag_i;
    end else begin : g_next
      assign q_in = q[s];
      assign r_in = r[s];
      assign d_in = d[s];
      assign t_in = t[s];
    end
    always_comb begin
      part = {r_in, q_in[DATA_WIDTH-1]};
      diff = part - {1'b0, d_in};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[DATA_WIDTH]) begin
          r[s+1] <= diff[DATA_WIDTH-1:0];
          q[s+1] <= {q_in[DATA_WIDTH-2:0], 1'b1};
        end else begin
          r[s+1] <= part[DATA_WIDTH-1:0];
          q[s+1] <= {q_in[DATA_WIDTH-2:0], 1'b0};
        end
        d[s+1] <= d_in;
        t[s+1] <= t_in;
      end
    end
  end

  assign quo   = q[DATA_WIDTH];
  assign rem   = r[DATA_WIDTH];
  assign tag_o = t[DATA_WIDTH];
endmodule

@@ src/wai_alu_back.sv @@
// ----------------------------------------------------------------------------
// wai_alu_back
// execute pipeline: shift, add, multiply, divide and result select
// ----------------------------------------------------------------------------
module wai_alu_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wai_alu_pkg::OpWidth-1:0] op,
  input  logic                            sgn,
  input  logic [DATA_WIDTH-1:0]           a,
  input  logic [DATA_WIDTH-1:0]           b,
  input  logic [DATA_WIDTH-1:0]           rmask,
  input  logic [wai_alu_pkg::WWidth:0]    rw,
  input  logic                            early,
  input  logic [DATA_WIDTH-1:0]           early_val,
  input  logic                            bad,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [DATA_WIDTH-1:0]           out_result,
  output logic                            out_bad
);
  localparam int WW = wai_alu_pkg::WWidth + 1;
  localparam int NST = DATA_WIDTH;
  // tag: valid, bad, div flags, mask, direct result
  localparam int TW = 1 + 1 + 4 + DATA_WIDTH + DATA_WIDTH;

  logic adv;
  logic [DATA_WIDTH-1:0] na, nb, ma, mb, direct, shl_v, shr_v, sxa;
  logic neg_a, neg_b, is_div, is_mod, dz;
  logic [DATA_WIDTH-1:0] prod;
  logic [TW-1:0] tag_in, tag_out;
  logic [DATA_WIDTH-1:0] quo, rem, fin;
  logic [NST-1:0] vld;
  logic o_valid;
  logic [DATA_WIDTH-1:0] o_res;
  logic o_bad;

  // pipeline moves whenever the output slot is free or being drained
  assign adv = !o_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    neg_a = a[$clog2(DATA_WIDTH)'(rw - WW'(1))] && sgn;
    neg_b = b[$clog2(DATA_WIDTH)'(rw - WW'(1))] && sgn;
    sxa = neg_a ? (a | ~rmask) : a;
    na = -a;
    nb = -b;
    ma = neg_a ? (na & rmask) : a;
    mb = neg_b ? (nb & rmask) : b;
    prod = a * b;
    if (b >= DATA_WIDTH'(rw)) shl_v = '0;
    else shl_v = a << b;
    if (b >= DATA_WIDTH'(rw)) shr_v = neg_a ? '1 : '0;
    else shr_v = neg_a ? ~((~sxa) >> b) : (a >> b);
    is_div = (op == wai_alu_pkg::OP_DIV);
    is_mod = (op == wai_alu_pkg::OP_MOD);
    dz = (b == '0);
    direct = '0;
    priority if (early || bad) direct = early_val;
    else begin
      unique case (op)
        wai_alu_pkg::OP_INV:  direct = ~a;
        wai_alu_pkg::OP_ANDB: direct = a & b;
        wai_alu_pkg::OP_ORB:  direct = a | b;
        wai_alu_pkg::OP_XORB: direct = a ^ b;
        wai_alu_pkg::OP_SHL:  direct = shl_v;
        wai_alu_pkg::OP_SHR:  direct = shr_v;
        wai_alu_pkg::OP_ADD:  direct = a + b;
        wai_alu_pkg::OP_SUB:  direct = a - b;
        wai_alu_pkg::OP_NEG:  direct = na;
        wai_alu_pkg::OP_MUL:  direct = prod;
        wai_alu_pkg::OP_DIV:  direct = rmask;
        wai_alu_pkg::OP_MOD:  direct = a;
        default:              direct = a;
      endcase
    end
    tag_in = {in_valid, bad, (is_div || is_mod) && !dz && !bad, is_div,
              neg_a, neg_b, rmask, direct & rmask};
  end

  wai_alu_divider #(.DATA_WIDTH(DATA_WIDTH), .TAG_WIDTH(TW)) u_div (
    .clk(clk), .adv(adv), .num(ma), .den(dz ? DATA_WIDTH'(1) : mb),
    .tag_i(tag_in), .quo(quo), .rem(rem), .tag_o(tag_out)
  );

  // valid bits of the divider stages carry reset
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], in_valid};
  end

  always_comb begin
    logic usediv, isd, sa, sb;
    logic [DATA_WIDTH-1:0] m, dr;
    usediv = tag_out[TW-3];
    isd    = tag_out[TW-4];
    sa     = tag_out[TW-5];
    sb     = tag_out[TW-6];
    m      = tag_out[2*DATA_WIDTH-1:DATA_WIDTH];
    dr     = tag_out[DATA_WIDTH-1:0];
    if (!usediv) fin = dr;
    else if (isd) fin = ((sa != sb) ? -quo : quo) & m;
    else fin = (sa ? -rem : rem) & m;
  end

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (adv) o_valid <= vld[NST-1];
    if (adv) begin
      o_res <= fin;
      o_bad <= tag_out[TW-2];
    end
  end

  assign out_valid  = o_valid;
  assign out_result = o_res;
  assign out_bad    = o_bad;
endmodule

@@ src/width_aware_integer_alu.sv @@
// ----------------------------------------------------------------------------
// width_aware_integer_alu
// integer alu with width aware resize, compare, shift, multiply and divide
// ----------------------------------------------------------------------------
// path: the queue entry of each request feeds DATA_WIDTH divider stages and
//   then the output register; a stall on the result side holds the pipeline
// throughput: one request per cycle while the result side does not stall, every operation takes the same path
// reset: rst synchronous active high clears queue pointers and count, stage valids and the output valid
module width_aware_integer_alu #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  wai_alu_req_if.sink   req,
  wai_alu_rsp_if.source rsp
);
  // front classification packed for the queue
  typedef struct packed {
    logic [wai_alu_pkg::OpWidth-1:0] op;
    logic                            sgn;
    logic [DATA_WIDTH-1:0]           a;
    logic [DATA_WIDTH-1:0]           b;
    logic [DATA_WIDTH-1:0]           rmask;
    logic [wai_alu_pkg::WWidth:0]    rw;
    logic                            early;
    logic [DATA_WIDTH-1:0]           early_val;
    logic                            bad;
  } cls_t;

  cls_t f, q;
  logic q_valid, q_ready;

  wai_alu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .opcode(req.opcode), .signed_mode(req.signed_mode),
    .operand_a(req.operand_a), .operand_b(req.operand_b),
    .a_width(req.a_width), .b_width(req.b_width),
    .result_width(req.result_width),
    .op_o(f.op), .sgn_o(f.sgn), .a_o(f.a), .b_o(f.b), .rmask_o(f.rmask),
    .rw_o(f.rw), .early_o(f.early), .early_val_o(f.early_val), .bad_o(f.bad)
  );

  // short queue decouples request side from execute stalls
  wai_alu_queue #(.WIDTH($bits(cls_t))) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready), .in_data(f),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q)
  );

  wai_alu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready),
    .op(q.op), .sgn(q.sgn), .a(q.a), .b(q.b), .rmask(q.rmask), .rw(q.rw),
    .early(q.early), .early_val(q.early_val), .bad(q.bad),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_result(rsp.result), .out_bad(rsp.bad_opcode)
  );
endmodule

@@ src/wai_alu_checker.sv @@
// ----------------------------------------------------------------------------
// wai_alu_checker
// port level checks of the alu
// ----------------------------------------------------------------------------
module wai_alu_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_result,
  input logic                  rsp_bad_opcode,
  input logic                  req_valid,
  input logic                  req_ready
);
  // a bad opcode result carries zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_bad_opcode |-> rsp_result == '0) else $error("bad opcode nonzero");
  // result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
    else $error("result changed under stall");
  // nothing comes out just after reset
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid) else $error("output after reset");
  // request side not blocked when output drains
  assert property (@(posedge clk) disable iff (rst)
    $past(rsp_ready) && $past(rsp_ready, 2) && $past(rsp_ready, 3) && !$past(rst, 3)
    |-> req_ready || !req_valid) else $error("request stalled");
endmodule

bind width_aware_integer_alu wai_alu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk(clk), .rst(rst),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.result),
  .rsp_bad_opcode(rsp.bad_opcode), .req_valid(req.valid), .req_ready(req.ready)
);
